FILE: hw/rtl/ipl_pkg.sv
// ----------------------------------------------------------------------------
// ipl_pkg
// Shared types and constants of the interval position locator.
// ----------------------------------------------------------------------------
package ipl_pkg;

  localparam int unsigned TAG_W    = 16;
  localparam int unsigned TAGNUM_W = 15;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } ipl_op_e;

  // Control bits that travel with each item down the pipeline.
  typedef struct packed {
    logic valid;    // stage holds an item
    logic is_load;  // item is a table load, not a query
    logic wr_ok;    // load slot lies inside the table
  } ipl_ctrl_t;

endpackage

FILE: hw/rtl/ipl_search_level.sv
// ----------------------------------------------------------------------------
// ipl_search_level
// One level of the binary search: a private copy of the begin table, read at
// the midpoint, and the compare that narrows the range for the next level.
// ----------------------------------------------------------------------------
module ipl_search_level #(
  parameter int unsigned MAX_INTERVALS = 4096,
  parameter int unsigned POSITION_BITS = 40,
  localparam int unsigned IDX_W = $clog2(MAX_INTERVALS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  ipl_pkg::ipl_ctrl_t           ctrl_i,
  input  logic [IDX_W-1:0]             lo_i,
  input  logic [IDX_W-1:0]             hi_i,
  input  logic [POSITION_BITS-1:0]     pos_i,
  input  logic [IDX_W-1:0]             ld_idx_i,
  input  logic [POSITION_BITS-1:0]     ld_begin_i,
  input  logic [POSITION_BITS-1:0]     ld_end_i,
  input  logic [POSITION_BITS-1:0]     ld_offset_i,
  input  logic [ipl_pkg::TAG_W-1:0]    ld_tag_i,
  output ipl_pkg::ipl_ctrl_t           ctrl_o,
  output logic [IDX_W-1:0]             lo_o,
  output logic [IDX_W-1:0]             hi_o,
  output logic [POSITION_BITS-1:0]     pos_o,
  output logic [IDX_W-1:0]             ld_idx_o,
  output logic [POSITION_BITS-1:0]     ld_begin_o,
  output logic [POSITION_BITS-1:0]     ld_end_o,
  output logic [POSITION_BITS-1:0]     ld_offset_o,
  output logic [ipl_pkg::TAG_W-1:0]    ld_tag_o
);
  import ipl_pkg::*;

  logic [POSITION_BITS-1:0] begin_mem [MAX_INTERVALS];
  logic [POSITION_BITS-1:0] rdata_q;
  logic [IDX_W:0]           half_sum;
  logic [IDX_W-1:0]         half_d;

  ipl_ctrl_t                ctrl_q;
  logic [IDX_W-1:0]         lo_q, hi_q, half_q, ld_idx_q;
  logic [POSITION_BITS-1:0] pos_q, ld_begin_q, ld_end_q, ld_offset_q;
  logic [TAG_W-1:0]         ld_tag_q;

  // Upper midpoint of the current range.
  assign half_sum = {1'b0, lo_i} + {1'b0, hi_i} + {{IDX_W{1'b0}}, 1'b1};
  assign half_d   = half_sum[IDX_W:1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ctrl_i.valid && ctrl_i.is_load && ctrl_i.wr_ok) begin
        begin_mem[ld_idx_i] <= ld_begin_i;
      end
      rdata_q <= begin_mem[half_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q        <= lo_i;
      hi_q        <= hi_i;
      half_q      <= half_d;
      pos_q       <= pos_i;
      ld_idx_q    <= ld_idx_i;
      ld_begin_q  <= ld_begin_i;
      ld_end_q    <= ld_end_i;
      ld_offset_q <= ld_offset_i;
      ld_tag_q    <= ld_tag_i;
    end
  end

  // Narrow the range; a settled range passes through unchanged.
  always_comb begin
    lo_o = lo_q;
    hi_o = hi_q;
    if (hi_q > lo_q) begin
      if (rdata_q > pos_q) begin
        hi_o = half_q - {{(IDX_W-1){1'b0}}, 1'b1};
      end else begin
        lo_o = half_q;
      end
    end
  end

  assign ctrl_o      = ctrl_q;
  assign pos_o       = pos_q;
  assign ld_idx_o    = ld_idx_q;
  assign ld_begin_o  = ld_begin_q;
  assign ld_end_o    = ld_end_q;
  assign ld_offset_o = ld_offset_q;
  assign ld_tag_o    = ld_tag_q;

endmodule

FILE: hw/rtl/ipl_entry_fetch.sv
// ----------------------------------------------------------------------------
// ipl_entry_fetch
// Holds the full interval table and reads the entry the search settled on.
// ----------------------------------------------------------------------------
module ipl_entry_fetch #(
  parameter int unsigned MAX_INTERVALS = 4096,
  parameter int unsigned POSITION_BITS = 40,
  localparam int unsigned IDX_W = $clog2(MAX_INTERVALS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  ipl_pkg::ipl_ctrl_t           ctrl_i,
  input  logic [IDX_W-1:0]             slot_i,
  input  logic [POSITION_BITS-1:0]     pos_i,
  input  logic [IDX_W-1:0]             ld_idx_i,
  input  logic [POSITION_BITS-1:0]     ld_begin_i,
  input  logic [POSITION_BITS-1:0]     ld_end_i,
  input  logic [POSITION_BITS-1:0]     ld_offset_i,
  input  logic [ipl_pkg::TAG_W-1:0]    ld_tag_i,
  output ipl_pkg::ipl_ctrl_t           ctrl_o,
  output logic [IDX_W-1:0]             slot_o,
  output logic [POSITION_BITS-1:0]     pos_o,
  output logic [POSITION_BITS-1:0]     begin_o,
  output logic [POSITION_BITS-1:0]     end_o,
  output logic [POSITION_BITS-1:0]     offset_o,
  output logic [ipl_pkg::TAG_W-1:0]    tag_o
);
  import ipl_pkg::*;

  logic [POSITION_BITS-1:0] begin_mem  [MAX_INTERVALS];
  logic [POSITION_BITS-1:0] end_mem    [MAX_INTERVALS];
  logic [POSITION_BITS-1:0] offset_mem [MAX_INTERVALS];
  logic [TAG_W-1:0]         tag_mem    [MAX_INTERVALS];

  ipl_ctrl_t                ctrl_q;
  logic [IDX_W-1:0]         slot_q;
  logic [POSITION_BITS-1:0] pos_q, begin_q, end_q, offset_q;
  logic [TAG_W-1:0]         tag_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ctrl_i.valid && ctrl_i.is_load && ctrl_i.wr_ok) begin
        begin_mem[ld_idx_i]  <= ld_begin_i;
        end_mem[ld_idx_i]    <= ld_end_i;
        offset_mem[ld_idx_i] <= ld_offset_i;
        tag_mem[ld_idx_i]    <= ld_tag_i;
      end
      begin_q  <= begin_mem[slot_i];
      end_q    <= end_mem[slot_i];
      offset_q <= offset_mem[slot_i];
      tag_q    <= tag_mem[slot_i];
      slot_q   <= slot_i;
      pos_q    <= pos_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  assign ctrl_o   = ctrl_q;
  assign slot_o   = slot_q;
  assign pos_o    = pos_q;
  assign begin_o  = begin_q;
  assign end_o    = end_q;
  assign offset_o = offset_q;
  assign tag_o    = tag_q;

endmodule

FILE: hw/rtl/ipl_map_calc.sv
// ----------------------------------------------------------------------------
// ipl_map_calc
// Three-stage position mapping: differences and flags, strand select, then
// the final offset add into the output register.
// ----------------------------------------------------------------------------
module ipl_map_calc #(
  parameter int unsigned MAX_INTERVALS = 4096,
  parameter int unsigned POSITION_BITS = 40,
  localparam int unsigned IDX_W = $clog2(MAX_INTERVALS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  ipl_pkg::ipl_ctrl_t            ctrl_i,
  input  logic [IDX_W-1:0]              slot_i,
  input  logic [POSITION_BITS-1:0]      pos_i,
  input  logic [POSITION_BITS-1:0]      begin_i,
  input  logic [POSITION_BITS-1:0]      end_i,
  input  logic [POSITION_BITS-1:0]      offset_i,
  input  logic [ipl_pkg::TAG_W-1:0]     tag_i,
  output logic                          out_valid_o,
  output logic [IDX_W-1:0]              slot_o,
  output logic [POSITION_BITS-1:0]      text_o,
  output logic                          reverse_o,
  output logic [ipl_pkg::TAGNUM_W-1:0]  tag_num_o,
  output logic                          inside_o
);
  import ipl_pkg::*;

  logic [TAG_W-1:0]         tag_neg;
  logic [TAGNUM_W-1:0]      mag_d;
  logic                     fwd_d;

  // Stage X
  logic                     vx_q, fwd_x_q, inside_x_q;
  logic [IDX_W-1:0]         slot_x_q;
  logic [POSITION_BITS-1:0] delta_x_q, len_x_q, off_x_q;
  logic [TAGNUM_W-1:0]      mag_x_q;
  // Stage Y
  logic                     vy_q, fwd_y_q, inside_y_q;
  logic [IDX_W-1:0]         slot_y_q;
  logic [POSITION_BITS-1:0] addend_y_q, off_y_q;
  logic [TAGNUM_W-1:0]      mag_y_q;
  // Stage Z (output)
  logic                     vz_q, fwd_z_q, inside_z_q;
  logic [IDX_W-1:0]         slot_z_q;
  logic [POSITION_BITS-1:0] text_z_q;
  logic [TAGNUM_W-1:0]      mag_z_q;

  // Zero counts as reverse; the most negative tag saturates.
  assign tag_neg = ~tag_i + {{(TAG_W-1){1'b0}}, 1'b1};
  assign fwd_d   = !tag_i[TAG_W-1] && (tag_i != '0);
  always_comb begin
    if (tag_i[TAG_W-1]) begin
      mag_d = tag_neg[TAG_W-1] ? {TAGNUM_W{1'b1}} : tag_neg[TAGNUM_W-1:0];
    end else begin
      mag_d = tag_i[TAGNUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= 1'b0;
      vy_q <= 1'b0;
      vz_q <= 1'b0;
    end else if (en_i) begin
      vx_q <= ctrl_i.valid && !ctrl_i.is_load;
      vy_q <= vx_q;
      vz_q <= vy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      delta_x_q  <= pos_i - begin_i;
      len_x_q    <= end_i - begin_i;
      off_x_q    <= offset_i;
      fwd_x_q    <= fwd_d;
      mag_x_q    <= mag_d;
      inside_x_q <= (begin_i <= pos_i) && (pos_i < end_i);
      slot_x_q   <= slot_i;

      addend_y_q <= fwd_x_q ? delta_x_q : (len_x_q - delta_x_q);
      off_y_q    <= off_x_q;
      fwd_y_q    <= fwd_x_q;
      mag_y_q    <= mag_x_q;
      inside_y_q <= inside_x_q;
      slot_y_q   <= slot_x_q;

      text_z_q   <= off_y_q + addend_y_q;
      fwd_z_q    <= fwd_y_q;
      mag_z_q    <= mag_y_q;
      inside_z_q <= inside_y_q;
      slot_z_q   <= slot_y_q;
    end
  end

  assign out_valid_o = vz_q;
  assign slot_o      = slot_z_q;
  assign text_o      = text_z_q;
  assign reverse_o   = !fwd_z_q;
  assign tag_num_o   = mag_z_q;
  assign inside_o    = inside_z_q;

endmodule

FILE: hw/rtl/interval_position_locator_core.sv
// ----------------------------------------------------------------------------
// interval_position_locator_core
// Maps an index position to a text location by binary search over a loaded
// table of sorted intervals.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries loads and queries. A load
//   writes one table slot and produces no result; a query produces exactly
//   one result on the output channel (out_valid_o/out_ready_i).
//   cfg_we_i/cfg_wdata_i set the number of searched intervals; write it
//   only while the pipeline is empty.
// Timing:
//   One transfer per cycle in each direction while no result is held
//   back. A query passes through the search levels, each level
//   registering its step and reading its own copy of the begin table,
//   then the entry fetch and two mapping stages ahead of the output
//   register.
//   Loads flow down the same pipeline and update each table copy as they
//   pass, so every query sees exactly the loads transferred before it.
// Reset and stall:
//   Reset empties the pipeline and sets the interval count to 1; the table
//   contents are undefined until loaded. While a result waits unaccepted
//   the whole pipeline holds and in_ready_o drops; nothing is lost.
// ----------------------------------------------------------------------------
module interval_position_locator_core #(
  parameter int unsigned MAX_INTERVALS = 4096,
  parameter int unsigned POSITION_BITS = 40,
  localparam int unsigned IDX_W = $clog2(MAX_INTERVALS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [IDX_W:0]                      cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [IDX_W-1:0]                    entry_index_i,
  input  logic [POSITION_BITS-1:0]            entry_begin_i,
  input  logic [POSITION_BITS-1:0]            entry_end_i,
  input  logic [POSITION_BITS-1:0]            entry_offset_i,
  input  logic signed [ipl_pkg::TAG_W-1:0]    entry_tag_i,
  input  logic [POSITION_BITS-1:0]            query_position_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [IDX_W-1:0]                    interval_index_o,
  output logic [POSITION_BITS-1:0]            text_position_o,
  output logic                                is_reverse_o,
  output logic [ipl_pkg::TAGNUM_W-1:0]        tag_number_o,
  output logic                                inside_res_o
);
  import ipl_pkg::*;

  localparam int unsigned LEVELS = (IDX_W < 1) ? 1 : IDX_W;
  localparam logic [IDX_W:0] MaxCount = (IDX_W+1)'(MAX_INTERVALS);

  logic             en;
  logic [IDX_W:0]   count_q;
  logic [IDX_W:0]   count_eff;
  logic [IDX_W:0]   count_m1;

  // Per-level chain; index 0 is the input side, index LEVELS feeds the fetch.
  ipl_ctrl_t                ctrl_s   [LEVELS+1];
  logic [IDX_W-1:0]         lo_s     [LEVELS+1];
  logic [IDX_W-1:0]         hi_s     [LEVELS+1];
  logic [POSITION_BITS-1:0] pos_s    [LEVELS+1];
  logic [IDX_W-1:0]         idx_s    [LEVELS+1];
  logic [POSITION_BITS-1:0] beg_s    [LEVELS+1];
  logic [POSITION_BITS-1:0] end_s    [LEVELS+1];
  logic [POSITION_BITS-1:0] off_s    [LEVELS+1];
  logic [TAG_W-1:0]         tag_s    [LEVELS+1];
  logic [LEVELS-1:0]        lvl_valid;

  ipl_ctrl_t                fch_ctrl;
  logic [IDX_W-1:0]         fch_slot;
  logic [POSITION_BITS-1:0] fch_pos, fch_begin, fch_end, fch_offset;
  logic [TAG_W-1:0]         fch_tag;

  // Advance the whole pipeline unless a finished result is held back.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Interval count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= (IDX_W+1)'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Clamp the count into 1..MAX_INTERVALS.
  always_comb begin
    if (count_q == '0) begin
      count_eff = (IDX_W+1)'(1);
    end else if (count_q > MaxCount) begin
      count_eff = MaxCount;
    end else begin
      count_eff = count_q;
    end
  end
  assign count_m1 = count_eff - (IDX_W+1)'(1);

  // Launch an accepted item into the first search level.
  assign ctrl_s[0].valid   = in_valid_i && en;
  assign ctrl_s[0].is_load = (operation_i == OP_LOAD);
  assign ctrl_s[0].wr_ok   = ({1'b0, entry_index_i} < MaxCount);
  assign lo_s[0]           = '0;
  assign hi_s[0]           = count_m1[IDX_W-1:0];
  assign pos_s[0]          = query_position_i;
  assign idx_s[0]          = entry_index_i;
  assign beg_s[0]          = entry_begin_i;
  assign end_s[0]          = entry_end_i;
  assign off_s[0]          = entry_offset_i;
  assign tag_s[0]          = entry_tag_i;

  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    ipl_search_level #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .POSITION_BITS (POSITION_BITS)
    ) u_level (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .ctrl_i      (ctrl_s[g]),
      .lo_i        (lo_s[g]),
      .hi_i        (hi_s[g]),
      .pos_i       (pos_s[g]),
      .ld_idx_i    (idx_s[g]),
      .ld_begin_i  (beg_s[g]),
      .ld_end_i    (end_s[g]),
      .ld_offset_i (off_s[g]),
      .ld_tag_i    (tag_s[g]),
      .ctrl_o      (ctrl_s[g+1]),
      .lo_o        (lo_s[g+1]),
      .hi_o        (hi_s[g+1]),
      .pos_o       (pos_s[g+1]),
      .ld_idx_o    (idx_s[g+1]),
      .ld_begin_o  (beg_s[g+1]),
      .ld_end_o    (end_s[g+1]),
      .ld_offset_o (off_s[g+1]),
      .ld_tag_o    (tag_s[g+1])
    );
    assign lvl_valid[g] = ctrl_s[g+1].valid;
  end

  ipl_entry_fetch #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .POSITION_BITS (POSITION_BITS)
  ) u_fetch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctrl_i      (ctrl_s[LEVELS]),
    .slot_i      (lo_s[LEVELS]),
    .pos_i       (pos_s[LEVELS]),
    .ld_idx_i    (idx_s[LEVELS]),
    .ld_begin_i  (beg_s[LEVELS]),
    .ld_end_i    (end_s[LEVELS]),
    .ld_offset_i (off_s[LEVELS]),
    .ld_tag_i    (tag_s[LEVELS]),
    .ctrl_o      (fch_ctrl),
    .slot_o      (fch_slot),
    .pos_o       (fch_pos),
    .begin_o     (fch_begin),
    .end_o       (fch_end),
    .offset_o    (fch_offset),
    .tag_o       (fch_tag)
  );

  ipl_map_calc #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .POSITION_BITS (POSITION_BITS)
  ) u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctrl_i      (fch_ctrl),
    .slot_i      (fch_slot),
    .pos_i       (fch_pos),
    .begin_i     (fch_begin),
    .end_i       (fch_end),
    .offset_i    (fch_offset),
    .tag_i       (fch_tag),
    .out_valid_o (out_valid_o),
    .slot_o      (interval_index_o),
    .text_o      (text_position_o),
    .reverse_o   (is_reverse_o),
    .tag_num_o   (tag_number_o),
    .inside_o    (inside_res_o)
  );

  // The search must have converged by the time a query leaves the last level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_s[LEVELS].valid && !ctrl_s[LEVELS].is_load) |-> (lo_s[LEVELS] == hi_s[LEVELS]))
    else $error("search range not settled after last level");

  // A held-back result freezes every search level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(lvl_valid))
    else $error("search pipeline moved during a stall");

  // A forward result always carries a nonzero tag number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_reverse_o) |-> (tag_number_o != '0))
    else $error("forward result with zero tag number");

endmodule
